>>> hw/rtl/ltd_pkg.sv
package ltd_pkg;

  localparam int KEY_W = 32;
  localparam int CNT_W = 7;
  localparam int CFG_W = 7;

  localparam int DEFAULT_CAPACITY = 64;
  localparam int DEFAULT_KEY_BITS = 32;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 7'd50;

  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic [CNT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic cmp;
    logic upd;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/lru_tag_directory_unit.sv
// an accepted item is compared in all cells as it is taken, each cell registering its match;
//   the ST_UPD state then applies it and loads its result into the output register
// one item at a time: in_ready is low in ST_UPD, so a new item waits until the last is applied
// the update waits while the output register still holds an untaken result
// reset: valid marks and entry count cleared at once, limit back to 50, keys left as is
module lru_tag_directory_unit #(
  parameter int CAPACITY = ltd_pkg::DEFAULT_CAPACITY,
  parameter int KEY_BITS = ltd_pkg::DEFAULT_KEY_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ltd_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ltd_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [ltd_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > ltd_pkg::CFG_W) ? CW : ltd_pkg::CFG_W;

  ltd_pkg::state_t state, state_next;

  logic [ltd_pkg::CFG_W-1:0] max_entries;
  logic [CW-1:0]             count, count_next;
  logic                      req_action;
  logic [KEY_BITS-1:0]       req_key;
  logic [KEY_BITS-1:0]       key_bus;
  ltd_pkg::cell_ctrl_t       ctrl;

  logic [KEY_BITS-1:0] cell_key  [CAPACITY];
  logic [KEY_BITS-1:0] cell_last [CAPACITY];
  logic [KEY_BITS-1:0] cell_prev [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY:0]   stop;

  logic [LW-1:0]       lim;
  logic                full, hit_any, insert_miss, evict, change;
  logic                accept, upd_go;
  logic [KEY_BITS-1:0] ev_or;

  assign in_ready = (state == ltd_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign upd_go   = (state == ltd_pkg::ST_UPD) && (!out_valid || out_ready);

  always_comb begin
    if (max_entries == '0) begin
      lim = LW'(1);
    end else if (LW'(max_entries) > LW'(CAPACITY)) begin
      lim = LW'(CAPACITY);
    end else begin
      lim = LW'(max_entries);
    end
  end

  assign full        = LW'(count) >= lim;
  assign hit_any     = stop[CAPACITY];
  assign insert_miss = (req_action == ltd_pkg::ACT_INSERT) && !hit_any;
  assign evict       = insert_miss && full;
  assign change      = ((req_action == ltd_pkg::ACT_ACCESS) && hit_any) || insert_miss;
  assign count_next  = (insert_miss && !full) ? count + CW'(1) : count;

  assign key_bus  = (state == ltd_pkg::ST_IDLE) ? KEY_BITS'(in_data.key) : req_key;
  assign ctrl.cmp = accept;
  assign ctrl.upd = upd_go && change;

  always_comb begin
    ev_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      ev_or = ev_or | cell_last[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ltd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ltd_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = ltd_pkg::ST_UPD;
        end
      end
      ltd_pkg::ST_UPD: begin
        if (upd_go) begin
          state_next = ltd_pkg::ST_IDLE;
        end
      end
      default: state_next = ltd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= ltd_pkg::MAX_ENTRIES_RESET;
      count       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_entries <= cfg_wdata;
      end
      if (upd_go) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= in_data.action;
      req_key    <= KEY_BITS'(in_data.key);
    end
    if (upd_go) begin
      out_data.hit         <= hit_any;
      out_data.evicted     <= evict;
      out_data.evicted_key <= evict ? ltd_pkg::KEY_W'(ev_or) : '0;
      out_data.entry_count <= ltd_pkg::CNT_W'(count_next);
    end
  end

  assign stop[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign cell_prev[g] = key_bus;
    end else begin : g_body
      assign cell_prev[g] = cell_key[g-1];
    end

    ltd_cell #(
      .IDX      (g),
      .KEY_BITS (KEY_BITS),
      .CW       (CW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .req_key    (key_bus),
      .count      (count),
      .count_next (count_next),
      .prev_key   (cell_prev[g]),
      .stop_in    (stop[g]),
      .key        (cell_key[g]),
      .valid      (cell_valid[g]),
      .match      (cell_match[g]),
      .stop_out   (stop[g+1]),
      .last_key   (cell_last[g])
    );
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    LW'(count) <= LW'(CAPACITY))
    else $error("entry count above capacity");

  a_unique_match : assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_match))
    else $error("key matched in more than one cell");

  a_evict_miss : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.evicted |-> !out_data.hit)
    else $error("eviction reported on a hit");

  a_head_valid : assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> cell_valid[0])
    else $error("nonzero count with empty head cell");

  a_valid_count : assert property (@(posedge clk) disable iff (rst)
    $past(upd_go) |-> ($countones(cell_valid) == int'(count)))
    else $error("valid cells disagree with entry count");

endmodule

>>> hw/rtl/ltd_cell.sv
module ltd_cell #(
  parameter int IDX      = 0,
  parameter int KEY_BITS = ltd_pkg::DEFAULT_KEY_BITS,
  parameter int CW       = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ltd_pkg::cell_ctrl_t  ctrl,
  input  logic [KEY_BITS-1:0]  req_key,
  input  logic [CW-1:0]        count,
  input  logic [CW-1:0]        count_next,
  input  logic [KEY_BITS-1:0]  prev_key,
  input  logic                 stop_in,
  output logic [KEY_BITS-1:0]  key,
  output logic                 valid,
  output logic                 match,
  output logic                 stop_out,
  output logic [KEY_BITS-1:0]  last_key
);

  // cell position equals recency rank, valid cells form a prefix
  logic is_last;

  assign is_last  = valid && (CW'(IDX + 1) == count);
  assign stop_out = stop_in | match;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctrl.cmp) begin
        match <= valid && (key == req_key);
      end
      if (ctrl.upd) begin
        valid <= CW'(IDX) < count_next;
      end
    end
  end

  // cells up to and including the hit position move one place older
  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      last_key <= is_last ? key : '0;
    end
    if (ctrl.upd && !stop_in) begin
      key <= prev_key;
    end
  end

endmodule

>>> bench/lru_dir_check_pkg.sv
`timescale 1ns / 1ps

package lru_dir_check_pkg;

  localparam int SLOTS = ltd_pkg::DEFAULT_CAPACITY;

  class lru_scoreboard;
    logic [ltd_pkg::KEY_W-1:0] slot_key [SLOTS];
    bit                        slot_valid [SLOTS];
    int unsigned               slot_rank [SLOTS];
    int unsigned               live_count;
    logic [ltd_pkg::CFG_W-1:0] limit_reg;
    ltd_pkg::out_item_t        predicted_replies [$];
    int                        errors;
    int                        replies_seen;
    int                        hits;
    int                        evictions;
    int                        peak_count;

    function new();
      foreach (slot_valid[i]) begin
        slot_valid[i] = 1'b0;
        slot_rank[i] = 0;
        slot_key[i] = '0;
      end
      live_count = 0;
      limit_reg = ltd_pkg::MAX_ENTRIES_RESET;
    endfunction

    function void set_limit(logic [ltd_pkg::CFG_W-1:0] v);
      limit_reg = v;
    endfunction

    function int pending();
      return predicted_replies.size();
    endfunction

    // applies one accepted item to the directory copy and queues its reply
    function void note_item(ltd_pkg::in_item_t it);
      int unsigned        lim;
      int                 slot;
      int                 target;
      int unsigned        old;
      ltd_pkg::out_item_t r;
      lim = (limit_reg == 0) ? 1 : ((limit_reg > SLOTS) ? SLOTS : int'(limit_reg));
      slot = -1;
      for (int i = 0; i < SLOTS; i++)
        if (slot < 0 && slot_valid[i] && slot_key[i] == it.key) slot = i;
      r = '0;
      if (slot >= 0) begin
        r.hit = 1'b1;
        hits++;
        if (it.action == ltd_pkg::ACT_ACCESS) begin
          old = slot_rank[slot];
          for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_rank[i] < old) slot_rank[i]++;
          slot_rank[slot] = 0;
        end
      end else if (it.action == ltd_pkg::ACT_INSERT) begin
        target = -1;
        if (live_count >= lim) begin
          // least recent valid entry, last index on a tie
          for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && (target < 0 || slot_rank[i] >= slot_rank[target])) target = i;
          if (target < 0) target = 0;
          if (slot_valid[target]) begin
            r.evicted = 1'b1;
            r.evicted_key = slot_key[target];
            slot_valid[target] = 1'b0;
            live_count--;
            evictions++;
          end
        end else begin
          for (int i = 0; i < SLOTS; i++)
            if (target < 0 && !slot_valid[i]) target = i;
          if (target < 0) target = 0;
        end
        for (int i = 0; i < SLOTS; i++)
          if (slot_valid[i]) slot_rank[i]++;
        slot_key[target] = it.key;
        slot_valid[target] = 1'b1;
        slot_rank[target] = 0;
        live_count++;
      end
      if (int'(live_count) > peak_count) peak_count = int'(live_count);
      r.entry_count = live_count[ltd_pkg::CNT_W-1:0];
      predicted_replies.push_back(r);
    endfunction

    task report_mismatch(string field, logic [ltd_pkg::KEY_W-1:0] got,
                         logic [ltd_pkg::KEY_W-1:0] want);
      $display("mismatch on reply %0d: %s got %0h want %0h", replies_seen, field, got, want);
      errors++;
    endtask

    task check_result(ltd_pkg::out_item_t got);
      ltd_pkg::out_item_t want;
      if (predicted_replies.size() == 0) begin
        report_mismatch("unexpected reply, entry_count",
                        ltd_pkg::KEY_W'(got.entry_count), '0);
      end else begin
        want = predicted_replies.pop_front();
        if (got.hit !== want.hit)
          report_mismatch("hit", ltd_pkg::KEY_W'(got.hit), ltd_pkg::KEY_W'(want.hit));
        if (got.evicted !== want.evicted)
          report_mismatch("evicted", ltd_pkg::KEY_W'(got.evicted),
                          ltd_pkg::KEY_W'(want.evicted));
        if (got.evicted_key !== want.evicted_key)
          report_mismatch("evicted_key", got.evicted_key, want.evicted_key);
        if (got.entry_count !== want.entry_count)
          report_mismatch("entry_count", ltd_pkg::KEY_W'(got.entry_count),
                          ltd_pkg::KEY_W'(want.entry_count));
      end
      replies_seen++;
    endtask
  endclass

endpackage

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 3000;
  localparam int POOL_SIZE = 96;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  ltd_pkg::in_item_t         in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  ltd_pkg::out_item_t        out_data;
  logic                      cfg_we = 1'b0;
  logic [ltd_pkg::CFG_W-1:0] cfg_wdata = '0;

  lru_dir_check_pkg::lru_scoreboard sb;
  bit                        calm = 1'b0;
  int                        stall_left = 0;
  int                        idle_cycles = 0;
  int                        limit_writes = 0;
  logic [ltd_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  lru_tag_directory_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // mostly back to back, some short gaps, a few long ones
  function int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function logic [ltd_pkg::KEY_W-1:0] pick_key(int pool_n);
    if ($urandom_range(0, 9) == 0) return $urandom();
    return key_pool[$urandom_range(0, pool_n - 1)];
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        stall_left <= idle_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task send_item(logic act, logic [ltd_pkg::KEY_W-1:0] key);
    int                gap;
    ltd_pkg::in_item_t it;
    gap = idle_len();
    it.action = act;
    it.key = key;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
  endtask

  // stop sending and let every outstanding reply come back
  task drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task write_limit(logic [ltd_pkg::CFG_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(v);
    limit_writes++;
  endtask

  task run_phase(logic [ltd_pkg::CFG_W-1:0] lim, int n, int pool_n, int insert_pct,
                 bit quiet);
    logic act;
    write_limit(lim);
    calm = quiet;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 49) == 0) drain();
      act = ($urandom_range(0, 99) < insert_pct) ? ltd_pkg::ACT_INSERT : ltd_pkg::ACT_ACCESS;
      send_item(act, pick_key(pool_n));
    end
  endtask

  initial begin
    sb = new();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset limit, empty directory first
    send_item(ltd_pkg::ACT_ACCESS, 32'h0000_0000);
    send_item(ltd_pkg::ACT_INSERT, 32'h0000_0000);
    send_item(ltd_pkg::ACT_INSERT, 32'h0000_0000);
    send_item(ltd_pkg::ACT_INSERT, 32'hFFFF_FFFF);
    send_item(ltd_pkg::ACT_INSERT, 32'h5555_5555);
    send_item(ltd_pkg::ACT_INSERT, 32'hAAAA_AAAA);
    send_item(ltd_pkg::ACT_ACCESS, 32'h0000_0000);
    send_item(ltd_pkg::ACT_ACCESS, 32'h1234_5678);
    send_item(ltd_pkg::ACT_ACCESS, 32'hFFFF_FFFF);
    send_item(ltd_pkg::ACT_INSERT, 32'h0000_0001);
    send_item(ltd_pkg::ACT_INSERT, 32'h8000_0000);
    send_item(ltd_pkg::ACT_INSERT, 32'h5555_5555);
    send_item(ltd_pkg::ACT_ACCESS, 32'h5555_5555);
    send_item(ltd_pkg::ACT_ACCESS, 32'h8000_0000);
    // limit of one: each new key pushes the last one out
    write_limit(7'd1);
    send_item(ltd_pkg::ACT_INSERT, 32'hDEAD_BEEF);
    send_item(ltd_pkg::ACT_INSERT, 32'h0000_0000);
    send_item(ltd_pkg::ACT_ACCESS, 32'hFFFF_FFFF);
    send_item(ltd_pkg::ACT_INSERT, 32'h0000_0000);
    send_item(ltd_pkg::ACT_INSERT, 32'hFFFF_FFFF);

    run_phase(7'd0, 70, 5, 60, 1'b0);
    run_phase(7'd1, 50, 4, 60, 1'b1);
    run_phase(7'd3, 90, 8, 55, 1'b0);
    run_phase(7'd127, 200, 90, 75, 1'b0);
    run_phase(7'd64, 110, 90, 55, 1'b1);
    // well below the current count, each insert miss evicts one entry and the count does not shrink
    run_phase(7'd5, 110, 90, 70, 1'b0);
    run_phase(7'd50, 250, 60, 50, 1'b0);

    calm = 1'b0;
    drain();
    repeat (10) @(posedge clk);
    $display("checked %0d replies over %0d limit writes, incl. 0, 1, 64 and 127",
             sb.replies_seen, limit_writes);
    $display("%0d hits, %0d evictions, peak occupancy %0d", sb.hits, sb.evictions,
             sb.peak_count);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
